// ===== hdl/scds_pkg.sv =====
// Shared types and constants for the strip-chart decimating store.
// Holds the sequencer state encoding, register map and field widths.
// No dependencies.
package scds_pkg;

    // APB register map
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_VALUE_LOW_0  = 3'd0;
    localparam logic [2:0] REG_GAIN_0       = 3'd1;
    localparam logic [2:0] REG_VALUE_LOW_1  = 3'd2;
    localparam logic [2:0] REG_GAIN_1       = 3'd3;
    localparam logic [2:0] REG_PIXEL_BOTTOM = 3'd4;
    localparam logic [2:0] REG_PIXEL_TOP    = 3'd5;

    localparam logic [31:0] GAIN_RESET   = 32'd9175040;
    localparam logic [14:0] BOTTOM_RESET = 15'd5;
    localparam logic [14:0] TOP_RESET    = 15'd145;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 56;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [15:0] HALVING_MAX = 16'hFFFF;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_START     = 12'b0000_0000_0010,
        S_RD        = 12'b0000_0000_0100,
        S_DEC_SETUP = 12'b0000_0000_1000,
        S_DEC_RD    = 12'b0000_0001_0000,
        S_DEC_WR    = 12'b0000_0010_0000,
        S_DIFF      = 12'b0000_0100_0000,
        S_MUL_LO    = 12'b0000_1000_0000,
        S_MUL_HI    = 12'b0001_0000_0000,
        S_SUM       = 12'b0010_0000_0000,
        S_ROUND     = 12'b0100_0000_0000,
        S_OUT       = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== hdl/strip_chart_decimating_store.sv =====
// Strip-chart decimating store. A read item passes through S_START and S_RD, where the
// point memory is read, to S_OUT. An add item passes through S_START, S_DIFF, S_MUL_LO,
// S_MUL_HI, S_SUM and S_ROUND to S_OUT, since the scaling runs through one shared 16x32
// multiplier twice, then offset add and rounding. Input is ready again in the cycle the
// result goes valid, so a new item is taken only once the last one has left S_OUT. An add
// to a full curve first halves every curve on the point memory, keeping every second entry
// of each curve of two or more points. One item in flight at a time.
// Reset: counts, halving counter and sequencer clear and config returns to its defaults
// at once; store is not cleared. Depends on scds_pkg.
module strip_chart_decimating_store #(
    parameter int NUM_CURVES = 2,
    parameter int MAX_POINTS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scds_pkg::IN_DATA_W-1:0]     s_tdata,  // sample_value[31:0], read_column[39:32]
    input  logic [scds_pkg::IN_USER_W-1:0]     s_tuser,  // mode[0], curve[1]
    // stream out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // column[7:0], pixel_row[23:8], in_view[24], decimated[25],
    // decimation_count[41:26], point_count[50:42], zero[55:51]
    output logic [scds_pkg::OUT_DATA_W-1:0]    m_tdata,
    // APB config
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scds_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int DEPTH = NUM_CURVES * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SRC_W = CNT_W + 1;
    localparam int CMP_W = CNT_W + 8;
    localparam int CUR_W = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
    localparam int OUT_DATA_W_L = scds_pkg::OUT_DATA_W;

    // ---------------- configuration ----------------
    logic [31:0] low0_reg, gain0_reg, low1_reg, gain1_reg;
    logic [14:0] bottom_reg, top_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low0_reg   <= '0;
            gain0_reg  <= scds_pkg::GAIN_RESET;
            low1_reg   <= '0;
            gain1_reg  <= scds_pkg::GAIN_RESET;
            bottom_reg <= scds_pkg::BOTTOM_RESET;
            top_reg    <= scds_pkg::TOP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                scds_pkg::REG_VALUE_LOW_0:  low0_reg   <= pwdata;
                scds_pkg::REG_GAIN_0:       gain0_reg  <= pwdata;
                scds_pkg::REG_VALUE_LOW_1:  low1_reg   <= pwdata;
                scds_pkg::REG_GAIN_1:       gain1_reg  <= pwdata;
                scds_pkg::REG_PIXEL_BOTTOM: bottom_reg <= pwdata[14:0];
                scds_pkg::REG_PIXEL_TOP:    top_reg    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            scds_pkg::REG_VALUE_LOW_0:  prdata = low0_reg;
            scds_pkg::REG_GAIN_0:       prdata = gain0_reg;
            scds_pkg::REG_VALUE_LOW_1:  prdata = low1_reg;
            scds_pkg::REG_GAIN_1:       prdata = gain1_reg;
            scds_pkg::REG_PIXEL_BOTTOM: prdata = {17'b0, bottom_reg};
            scds_pkg::REG_PIXEL_TOP:    prdata = {17'b0, top_reg};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- point memory ----------------
    logic [15:0]   mem [DEPTH];
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [15:0]   wr_data;
    logic [15:0]   rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------- control state ----------------
    scds_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   count_reg [NUM_CURVES];
    logic [CNT_W-1:0]   count_next [NUM_CURVES];
    logic [15:0]        halving_reg, halving_next;
    logic [CUR_W-1:0]   dec_cur_reg, dec_cur_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // ---------------- payload ----------------
    logic               mode_reg, mode_next;
    logic               curve_reg, curve_next;
    logic [31:0]        sample_reg, sample_next;
    logic [7:0]         rcol_reg, rcol_next;
    logic               dec_flag_reg, dec_flag_next;
    logic [CNT_W-1:0]   dec_n_reg, dec_n_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [SRC_W-1:0]   dst_reg, dst_next;
    logic               neg_reg, neg_next;
    logic [31:0]        mag_reg, mag_next;
    logic [63:0]        acc_reg, acc_next;
    logic [65:0]        sum_reg, sum_next;
    logic [15:0]        row_reg, row_next;
    logic [OUT_DATA_W_L-1:0] out_reg, out_next;

    // ---------------- datapath helpers ----------------
    logic [CUR_W-1:0] cur_idx;
    logic             cur_ok;
    logic [31:0]      low_sel, gain_sel;
    logic [CNT_W-1:0] cnt_cur;
    logic [AW-1:0]    base_cur, base_dec;
    logic [32:0]      diff_fwd, diff_rev;
    logic [15:0]      mul_a;
    logic [47:0]      pp;
    logic [65:0]      bot66, rnd;
    logic [33:0]      ipart;
    logic [15:0]      row_sat;
    logic             rd_ok;
    logic [15:0]      row_out;
    logic             view_out;
    logic [7:0]       col_out;
    logic [CNT_W-1:0] cnt_out;
    logic             out_free;

    assign cur_idx  = CUR_W'(curve_reg);
    assign cur_ok   = (int'(curve_reg) < NUM_CURVES);
    assign low_sel  = curve_reg ? low1_reg  : low0_reg;
    assign gain_sel = curve_reg ? gain1_reg : gain0_reg;
    assign cnt_cur  = count_reg[cur_idx];
    assign base_cur = AW'(MAX_POINTS) * AW'(cur_idx);
    assign base_dec = AW'(MAX_POINTS) * AW'(dec_cur_reg);

    assign diff_fwd = {sample_reg[31], sample_reg} - {low_sel[31], low_sel};
    assign diff_rev = {low_sel[31], low_sel} - {sample_reg[31], sample_reg};

    // shared multiplier: one 16-bit slice of the magnitude per cycle
    assign mul_a = (state_reg == scds_pkg::S_MUL_HI) ? mag_reg[31:16] : mag_reg[15:0];
    assign pp    = 48'(mul_a) * 48'(gain_sel);

    assign bot66 = {19'b0, bottom_reg, 32'b0};
    // truncate toward zero: bias negative sums before dropping the fraction
    assign rnd   = sum_reg[65] ? (sum_reg + 66'h0_FFFF_FFFF) : sum_reg;
    assign ipart = rnd[65:32];

    always_comb
    begin
        if (ipart[33:15] == {19{ipart[33]}})
        begin
            row_sat = ipart[15:0];
        end
        else if (ipart[33])
        begin
            row_sat = 16'h8000;
        end
        else
        begin
            row_sat = 16'h7FFF;
        end
    end

    assign rd_ok = (CMP_W'(rcol_reg) < CMP_W'(cnt_cur)) &&
                   (CMP_W'(rcol_reg) < CMP_W'(MAX_POINTS));

    always_comb
    begin
        row_out = '0;
        col_out = '0;
        cnt_out = '0;
        if (cur_ok)
        begin
            if (mode_reg == scds_pkg::MODE_ADD)
            begin
                row_out = row_reg;
                col_out = 8'(cnt_cur);
                cnt_out = cnt_cur + CNT_W'(1);
            end
            else
            begin
                row_out = rd_ok ? rd_data_reg : 16'h0000;
                col_out = rcol_reg;
                cnt_out = cnt_cur;
            end
        end
    end

    assign view_out = cur_ok && ((mode_reg == scds_pkg::MODE_ADD) || rd_ok) &&
                      ($signed(row_out) >= $signed({2'b0, bottom_reg})) &&
                      ($signed(row_out) <= $signed({2'b0, top_reg}));

    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        halving_next  = halving_reg;
        dec_cur_next  = dec_cur_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        mode_next     = mode_reg;
        curve_next    = curve_reg;
        sample_next   = sample_reg;
        rcol_next     = rcol_reg;
        dec_flag_next = dec_flag_reg;
        dec_n_next    = dec_n_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;
        row_next      = row_reg;
        out_next      = out_reg;
        rd_en         = 1'b0;
        rd_addr       = base_cur + AW'(rcol_reg);
        wr_en         = 1'b0;
        wr_addr       = base_cur + AW'(cnt_cur);
        wr_data       = row_reg;

        case (state_reg)
            scds_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next     = s_tuser[0];
                    curve_next    = s_tuser[1];
                    sample_next   = s_tdata[31:0];
                    rcol_next     = s_tdata[39:32];
                    dec_flag_next = 1'b0;
                    state_next    = scds_pkg::S_START;
                end
            end
            scds_pkg::S_START:
            begin
                if (!cur_ok)
                begin
                    state_next = scds_pkg::S_OUT;
                end
                else if (mode_reg == scds_pkg::MODE_READ)
                begin
                    state_next = scds_pkg::S_RD;
                end
                else if (CMP_W'(cnt_cur) >= CMP_W'(MAX_POINTS))
                begin
                    dec_flag_next = 1'b1;
                    dec_cur_next  = '0;
                    state_next    = scds_pkg::S_DEC_SETUP;
                end
                else
                begin
                    state_next = scds_pkg::S_DIFF;
                end
            end
            scds_pkg::S_RD:
            begin
                rd_en      = 1'b1;
                state_next = scds_pkg::S_OUT;
            end
            scds_pkg::S_DEC_SETUP:
            begin
                dec_n_next = count_reg[dec_cur_reg];
                src_next   = SRC_W'(2);
                dst_next   = SRC_W'(1);
                if (count_reg[dec_cur_reg] > CNT_W'(1))
                begin
                    state_next = scds_pkg::S_DEC_RD;
                end
                else if (dec_cur_reg == CUR_W'(NUM_CURVES - 1))
                begin
                    if (halving_reg != scds_pkg::HALVING_MAX)
                    begin
                        halving_next = halving_reg + 16'd1;
                    end
                    state_next = scds_pkg::S_DIFF;
                end
                else
                begin
                    dec_cur_next = dec_cur_reg + CUR_W'(1);
                end
            end
            scds_pkg::S_DEC_RD:
            begin
                rd_addr = base_dec + AW'(src_reg);
                if (src_reg < SRC_W'(dec_n_reg))
                begin
                    rd_en      = 1'b1;
                    state_next = scds_pkg::S_DEC_WR;
                end
                else
                begin
                    // curve done: the count becomes the number kept
                    count_next[dec_cur_reg] = CNT_W'(dst_reg);
                    if (dec_cur_reg == CUR_W'(NUM_CURVES - 1))
                    begin
                        if (halving_reg != scds_pkg::HALVING_MAX)
                        begin
                            halving_next = halving_reg + 16'd1;
                        end
                        state_next = scds_pkg::S_DIFF;
                    end
                    else
                    begin
                        dec_cur_next = dec_cur_reg + CUR_W'(1);
                        state_next   = scds_pkg::S_DEC_SETUP;
                    end
                end
            end
            scds_pkg::S_DEC_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = base_dec + AW'(dst_reg);
                wr_data    = rd_data_reg;
                src_next   = src_reg + SRC_W'(2);
                dst_next   = dst_reg + SRC_W'(1);
                state_next = scds_pkg::S_DEC_RD;
            end
            scds_pkg::S_DIFF:
            begin
                neg_next   = diff_fwd[32];
                mag_next   = diff_fwd[32] ? diff_rev[31:0] : diff_fwd[31:0];
                state_next = scds_pkg::S_MUL_LO;
            end
            scds_pkg::S_MUL_LO:
            begin
                acc_next   = 64'(pp);
                state_next = scds_pkg::S_MUL_HI;
            end
            scds_pkg::S_MUL_HI:
            begin
                acc_next   = acc_reg + {pp, 16'b0};
                state_next = scds_pkg::S_SUM;
            end
            scds_pkg::S_SUM:
            begin
                sum_next   = neg_reg ? (bot66 - {2'b0, acc_reg}) : (bot66 + {2'b0, acc_reg});
                state_next = scds_pkg::S_ROUND;
            end
            scds_pkg::S_ROUND:
            begin
                row_next   = row_sat;
                state_next = scds_pkg::S_OUT;
            end
            scds_pkg::S_OUT:
            begin
                // hold the finished item until the output register frees up
                if (out_free)
                begin
                    out_next = {5'b0, 9'(cnt_out), halving_reg,
                                dec_flag_reg & (mode_reg == scds_pkg::MODE_ADD),
                                view_out, row_out, col_out};
                    m_tvalid_next = 1'b1;
                    if (cur_ok && (mode_reg == scds_pkg::MODE_ADD))
                    begin
                        wr_en               = 1'b1;
                        count_next[cur_idx] = cnt_cur + CNT_W'(1);
                    end
                    state_next = scds_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= scds_pkg::S_IDLE;
            count_reg    <= '{default: '0};
            halving_reg  <= '0;
            dec_cur_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            halving_reg  <= halving_next;
            dec_cur_reg  <= dec_cur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        curve_reg    <= curve_next;
        sample_reg   <= sample_next;
        rcol_reg     <= rcol_next;
        dec_flag_reg <= dec_flag_next;
        dec_n_reg    <= dec_n_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        acc_reg      <= acc_next;
        sum_reg      <= sum_next;
        row_reg      <= row_next;
        out_reg      <= out_next;
    end

    assign s_tready = (state_reg == scds_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // ---------------- assertions ----------------
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scds_pkg::S_DEC_WR) |-> (dst_reg < src_reg))
        else $error("halving copy overtook its source");

    a_halving_step: assert property (@(posedge clk) disable iff (!rst_n)
        (halving_reg != $past(halving_reg)) |-> (halving_reg == $past(halving_reg) + 16'd1))
        else $error("halving counter moved by more than one");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg[0]) <= CMP_W'(MAX_POINTS))
        else $error("curve count beyond capacity");

endmodule
